@@ rtl/cwsl_pkg.sv @@
package cwsl_pkg;

   // Store geometry.
   localparam int MAX_CHUNKS    = 8;
   localparam int MAX_CHUNK_LEN = 64;
   localparam int ROW_W         = 3;
   localparam int COL_W         = 6;
   localparam int ADDR_W        = ROW_W + COL_W;
   localparam int STORE_DEPTH   = MAX_CHUNKS * MAX_CHUNK_LEN;

   // Field widths.
   localparam int CMD_W   = 2;
   localparam int VAL_W   = 16;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 4;
   localparam int LEN_W   = 7;
   localparam int CSR_W   = 7;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_WRITE_WEIGHT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FORWARD      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BACKWARD     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_GRAD    = 2'd3;

   // Result kinds.
   localparam logic [1:0] KIND_COL_SUM    = 2'd0;
   localparam logic [1:0] KIND_INPUT_GRAD = 2'd1;
   localparam logic [1:0] KIND_WEIGHT_GRAD = 2'd2;

   // Result status.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_CHUNK_COUNT  = 1'b0;
   localparam logic CSR_CHUNK_LENGTH = 1'b1;

   // One input beat.
   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] col_grad;
      logic                    want_input_grad;
   } item_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]              kind;
      logic [ROW_W-1:0]        out_row;
      logic [COL_W-1:0]        out_col;
      logic signed [SUM_W-1:0] result_value;
      logic [1:0]              status;
   } result_type;

   // Accumulator or gradient entry with its sticky saturation flag.
   typedef struct packed {
      logic                    sat;
      logic signed [SUM_W-1:0] sum;
   } acc_type;

   // Store updates produced by the datapath for one item.
   typedef struct packed {
      logic                    w_we;
      logic signed [VAL_W-1:0] w_data;
      logic                    g_we;
      acc_type                 g_data;
      logic                    a_we;
      acc_type                 a_data;
   } upd_type;

endpackage

@@ rtl/cwsl_ram.sv @@
module cwsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port that holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cwsl_alu.sv @@
module cwsl_alu (
   input  cwsl_pkg::item_type                    item,
   input  logic [cwsl_pkg::COUNT_W-1:0]          chunk_count,
   input  logic [cwsl_pkg::LEN_W-1:0]            chunk_length,
   input  logic signed [cwsl_pkg::VAL_W-1:0]     weight,
   input  cwsl_pkg::acc_type                     grad_entry,
   input  cwsl_pkg::acc_type                     acc_entry,
   output cwsl_pkg::upd_type                     upd,
   output logic                                  rsp_en,
   output cwsl_pkg::result_type                  result
);

   import cwsl_pkg::*;

   logic [COUNT_W-1:0]      cnt_eff;
   logic [LEN_W-1:0]        len_eff;
   logic                    out_of_range;
   logic                    last_row;
   logic signed [VAL_W-1:0] mul_b;
   logic signed [SUM_W-1:0] prod_a;
   logic signed [SUM_W-1:0] prod_w;
   acc_type                 acc_sum;
   acc_type                 grad_sum;

   // Saturating 32-bit add; the flag is set on clipping.
   function automatic acc_type sat_add(input acc_type a, input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      acc_type               r;
      s = {a.sum[SUM_W-1], a.sum} + {b[SUM_W-1], b};
      r.sat = a.sat;
      r.sum = s[SUM_W-1:0];
      if (s[SUM_W] != s[SUM_W-1]) begin
         r.sat = 1'b1;
         r.sum = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return r;
   endfunction

   // Clamp the configuration into the supported ranges.
   always_comb begin
      cnt_eff = chunk_count;
      if (chunk_count == '0) begin
         cnt_eff = COUNT_W'(1);
      end else if (chunk_count > COUNT_W'(MAX_CHUNKS)) begin
         cnt_eff = COUNT_W'(MAX_CHUNKS);
      end
      len_eff = chunk_length;
      if (chunk_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (chunk_length > LEN_W'(MAX_CHUNK_LEN)) begin
         len_eff = LEN_W'(MAX_CHUNK_LEN);
      end
   end

   assign out_of_range = ({1'b0, item.row} >= cnt_eff) || ({1'b0, item.col} >= len_eff);
   assign last_row     = ({1'b0, item.row} == (cnt_eff - COUNT_W'(1)));

   // Activation times weight (forward) or activation times column gradient
   // (backward) share one multiplier; weight times gradient has its own.
   assign mul_b  = (item.command == CMD_FORWARD) ? weight : item.col_grad;
   assign prod_a = SUM_W'(item.value * mul_b);
   assign prod_w = SUM_W'(weight * item.col_grad);

   // Row 0 starts the column over, later rows accumulate.
   always_comb begin
      if (item.row == '0) begin
         acc_sum.sat = 1'b0;
         acc_sum.sum = prod_a;
      end else begin
         acc_sum = sat_add(acc_entry, prod_a);
      end
   end

   assign grad_sum = sat_add(grad_entry, prod_a);

   // Store updates and the result for each command.
   always_comb begin
      upd                 = '0;
      upd.w_data          = item.value;
      upd.g_data          = grad_sum;
      upd.a_data          = acc_sum;
      rsp_en              = 1'b0;
      result.kind         = KIND_COL_SUM;
      result.out_row      = item.row;
      result.out_col      = item.col;
      result.result_value = '0;
      result.status       = ST_OK;
      case (item.command)
         CMD_WRITE_WEIGHT: begin
            upd.w_we = !out_of_range;
         end
         CMD_FORWARD: begin
            upd.a_we            = !out_of_range;
            rsp_en              = out_of_range || last_row;
            result.kind         = KIND_COL_SUM;
            result.result_value = acc_sum.sum;
            result.status       = acc_sum.sat ? ST_SAT : ST_OK;
         end
         CMD_BACKWARD: begin
            upd.g_we            = !out_of_range;
            rsp_en              = out_of_range || item.want_input_grad;
            result.kind         = KIND_INPUT_GRAD;
            result.result_value = prod_w;
         end
         default: begin
            upd.g_we            = !out_of_range;
            upd.g_data          = '0;
            rsp_en              = 1'b1;
            result.kind         = KIND_WEIGHT_GRAD;
            result.result_value = grad_entry.sum;
            result.status       = grad_entry.sat ? ST_SAT : ST_OK;
         end
      endcase
      // Out-of-range items report the range error and carry a zero value.
      if (out_of_range) begin
         result.result_value = '0;
         result.status       = ST_RANGE;
      end
   end

endmodule

@@ rtl/chunk_weighted_sum_layer.sv @@
// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_ready  command, row, col, value, col_grad, want flag
// rsp      out        rsp_valid/rsp_ready  kind, row, col, result value, status
// csr      in         csr_we               register index and write data, no wait
//
// One beat per cycle is accepted unless a stalled result or the clear sweep
// holds req_ready low; the store reads are registered with the beat, then
// multiply, saturating add and write back into the result register follow.
// After reset the weight-gradient store is swept to zero, one entry per cycle,
// and req_ready stays low until all 512 entries are cleared.
// A stalled result holds the compute stage, which in turn holds req_ready low.
module chunk_weighted_sum_layer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cwsl_pkg::CMD_W-1:0]            req_command,
   input  logic [cwsl_pkg::ROW_W-1:0]            req_row,
   input  logic [cwsl_pkg::COL_W-1:0]            req_col,
   input  logic signed [cwsl_pkg::VAL_W-1:0]     req_value,
   input  logic signed [cwsl_pkg::VAL_W-1:0]     req_col_grad,
   input  logic                                  req_want_input_grad,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_kind,
   output logic [cwsl_pkg::ROW_W-1:0]            rsp_out_row,
   output logic [cwsl_pkg::COL_W-1:0]            rsp_out_col,
   output logic signed [cwsl_pkg::SUM_W-1:0]     rsp_result_value,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [cwsl_pkg::CSR_W-1:0]            csr_wdata
);

   import cwsl_pkg::*;

   localparam int ACC_W = SUM_W + 1;

   logic [COUNT_W-1:0]      chunk_count_ff;
   logic [LEN_W-1:0]        chunk_length_ff;
   logic                    clear_active_ff;
   logic [ADDR_W-1:0]       clear_addr_ff;

   logic                    s1_valid_ff, s1_valid_in;
   item_type                s1_item_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff;

   logic                    fwd_w_hit_ff, fwd_g_hit_ff, fwd_a_hit_ff;
   logic signed [VAL_W-1:0] fwd_w_ff;
   acc_type                 fwd_g_ff, fwd_a_ff;

   logic                    accept;
   logic                    s1_move;
   logic                    s1_commit;
   logic [ADDR_W-1:0]       req_addr;
   logic [ADDR_W-1:0]       s1_addr;
   item_type                req_item;

   logic [VAL_W-1:0]        w_rd;
   logic [ACC_W-1:0]        g_rd, a_rd;
   logic signed [VAL_W-1:0] weight;
   acc_type                 grad_entry, acc_entry;
   upd_type                 upd;
   logic                    alu_rsp_en;
   result_type              alu_result;

   logic                    g_wr_en;
   logic [ADDR_W-1:0]       g_wr_addr;
   logic [ACC_W-1:0]        g_wr_data;

   // Handshake and stage advance.
   assign s1_move   = !rsp_valid_ff || rsp_ready;
   assign s1_commit = s1_valid_ff && s1_move;
   assign req_ready = !clear_active_ff && (!s1_valid_ff || s1_move);
   assign accept    = req_valid && req_ready;

   assign req_item.command         = req_command;
   assign req_item.row             = req_row;
   assign req_item.col             = req_col;
   assign req_item.value           = req_value;
   assign req_item.col_grad        = req_col_grad;
   assign req_item.want_input_grad = req_want_input_grad;

   assign req_addr = {req_row, req_col};
   assign s1_addr  = {s1_item_ff.row, s1_item_ff.col};

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff  <= COUNT_W'(1);
         chunk_length_ff <= LEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHUNK_COUNT:  chunk_count_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_CHUNK_LENGTH: chunk_length_ff <= csr_wdata[LEN_W-1:0];
            default:          chunk_count_ff  <= chunk_count_ff;
         endcase
      end
   end

   // Gradient store clearing sweep after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else if (clear_active_ff) begin
         clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clear_active_ff <= 1'b0;
         end
      end
   end

   // Stores.
   cwsl_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (s1_commit && upd.w_we),
      .wr_addr (s1_addr),
      .wr_data (upd.w_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (w_rd)
   );

   assign g_wr_en   = clear_active_ff || (s1_commit && upd.g_we);
   assign g_wr_addr = clear_active_ff ? clear_addr_ff : s1_addr;
   assign g_wr_data = clear_active_ff ? '0 : upd.g_data;

   cwsl_ram #(.WIDTH(ACC_W), .DEPTH(STORE_DEPTH)) u_grad_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (g_rd)
   );

   cwsl_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CHUNK_LEN)) u_acc_ram (
      .clock   (clock),
      .wr_en   (s1_commit && upd.a_we),
      .wr_addr (s1_item_ff.col),
      .wr_data (upd.a_data),
      .rd_en   (accept),
      .rd_addr (req_col),
      .rd_data (a_rd)
   );

   // Bypass: a store read issued in the same cycle as a write to the same
   // entry sees old data, so capture the written value alongside the read.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= req_item;
         fwd_w_hit_ff <= s1_commit && upd.w_we && (s1_addr == req_addr);
         fwd_g_hit_ff <= s1_commit && upd.g_we && (s1_addr == req_addr);
         fwd_a_hit_ff <= s1_commit && upd.a_we && (s1_item_ff.col == req_col);
         fwd_w_ff     <= upd.w_data;
         fwd_g_ff     <= upd.g_data;
         fwd_a_ff     <= upd.a_data;
      end
   end

   assign weight     = fwd_w_hit_ff ? fwd_w_ff : w_rd;
   assign grad_entry = fwd_g_hit_ff ? fwd_g_ff : g_rd;
   assign acc_entry  = fwd_a_hit_ff ? fwd_a_ff : a_rd;

   // Multiply, accumulate and result selection.
   cwsl_alu u_alu (
      .item         (s1_item_ff),
      .chunk_count  (chunk_count_ff),
      .chunk_length (chunk_length_ff),
      .weight       (weight),
      .grad_entry   (grad_entry),
      .acc_entry    (acc_entry),
      .upd          (upd),
      .rsp_en       (alu_rsp_en),
      .result       (alu_result)
   );

   // Stage valid and result register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_move ? (s1_commit && alu_rsp_en) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_commit && alu_rsp_en) begin
         rsp_ff <= alu_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_out_row      = rsp_ff.out_row;
   assign rsp_out_col      = rsp_ff.out_col;
   assign rsp_result_value = rsp_ff.result_value;
   assign rsp_status       = rsp_ff.status;

   // No beat is taken while the gradient store is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !req_ready)
      else $error("beat accepted during gradient clear");

   // A stalled compute stage keeps its item.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("compute stage lost its item while stalled");

   // Input gradients never report saturation.
   a_igrad_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |-> (rsp_kind != KIND_INPUT_GRAD))
      else $error("input gradient flagged as saturated");

   // Range errors carry a zero value.
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RANGE) |-> (rsp_result_value == '0))
      else $error("range error with nonzero value");

endmodule

@@ verif/testbench.sv @@
module testbench;
   import cwsl_pkg::*;

   // Q1.14 corner values.
   localparam logic [VAL_W-1:0] Q_MIN     = 16'h8000;
   localparam logic [VAL_W-1:0] Q_MAX     = 16'h7FFF;
   localparam logic [VAL_W-1:0] Q_NEG_MAX = 16'h8001;
   localparam logic [VAL_W-1:0] Q_NEG_ONE = 16'hFFFF;
   localparam logic [VAL_W-1:0] Q_ONE     = 16'h0001;
   localparam logic [VAL_W-1:0] Q_ZERO    = 16'h0000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 300;

   // Mirror of the layer: weights, gradient store and column sums, with the
   // expected result beats in acceptance order.
   class layer_scoreboard;
      int count_reg;
      int length_reg;
      logic [VAL_W-1:0] weight_mem [STORE_DEPTH];
      int grad_store [STORE_DEPTH];
      bit grad_flag [STORE_DEPTH];
      int col_sum [MAX_CHUNK_LEN];
      bit col_flag [MAX_CHUNK_LEN];
      result_type pending_results[$];
      int errors;
      int checked;
      int sat_seen;
      int range_seen;

      function new();
         count_reg = 1;
         length_reg = 1;
         errors = 0;
         checked = 0;
         sat_seen = 0;
         range_seen = 0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            weight_mem[i] = '0;
            grad_store[i] = 0;
            grad_flag[i] = 1'b0;
         end
         for (int i = 0; i < MAX_CHUNK_LEN; i++) begin
            col_sum[i] = 0;
            col_flag[i] = 1'b0;
         end
      endfunction

      function void write_register(logic idx, logic [CSR_W-1:0] data);
         if (idx == CSR_CHUNK_COUNT) begin
            count_reg = int'(data[COUNT_W-1:0]);
         end else begin
            length_reg = int'(data[LEN_W-1:0]);
         end
      endfunction

      // Register values as the block uses them, clamped to the store size.
      function int eff_count();
         int n;
         n = count_reg;
         if (n < 1) n = 1;
         if (n > MAX_CHUNKS) n = MAX_CHUNKS;
         return n;
      endfunction

      function int eff_length();
         int n;
         n = length_reg;
         if (n < 1) n = 1;
         if (n > MAX_CHUNK_LEN) n = MAX_CHUNK_LEN;
         return n;
      endfunction

      function int widen(logic [VAL_W-1:0] x);
         return {{(SUM_W-VAL_W){x[VAL_W-1]}}, x};
      endfunction

      // Add that sticks at the 32-bit limits and raises the flag when it does.
      function int clamp_add(int a, int b, inout bit flag);
         longint s;
         s = longint'(a) + longint'(b);
         if (s > longint'(32'sh7FFFFFFF)) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
         end
         if (s < -longint'(64'sh80000000)) begin
            flag = 1'b1;
            return 32'sh80000000;
         end
         return int'(s);
      endfunction

      function result_type make_result(logic [1:0] kind, item_type it, int value,
                                        logic [1:0] status);
         result_type r;
         r.kind = kind;
         r.out_row = it.row;
         r.out_col = it.col;
         r.result_value = value;
         r.status = status;
         return r;
      endfunction

      // Applies one accepted beat and queues the result it should produce.
      function void note_beat(item_type it);
         int cnt;
         int len;
         int addr;
         int c;
         int prod;
         bit flag;
         cnt = eff_count();
         len = eff_length();
         c = int'(it.col);
         if (int'(it.row) >= cnt || int'(it.col) >= len) begin
            case (it.command)
               CMD_FORWARD:
                  pending_results.push_back(make_result(KIND_COL_SUM, it, 0, ST_RANGE));
               CMD_BACKWARD:
                  pending_results.push_back(make_result(KIND_INPUT_GRAD, it, 0, ST_RANGE));
               CMD_READ_GRAD:
                  pending_results.push_back(make_result(KIND_WEIGHT_GRAD, it, 0, ST_RANGE));
               default: ;
            endcase
            return;
         end
         addr = int'(it.row) * MAX_CHUNK_LEN + c;
         case (it.command)
            CMD_WRITE_WEIGHT: begin
               weight_mem[addr] = it.value;
            end
            CMD_FORWARD: begin
               prod = widen(it.value) * widen(weight_mem[addr]);
               // Row 0 opens a fresh column sum.
               if (it.row == 0) begin
                  col_sum[c] = prod;
                  col_flag[c] = 1'b0;
               end else begin
                  flag = col_flag[c];
                  col_sum[c] = clamp_add(col_sum[c], prod, flag);
                  col_flag[c] = flag;
               end
               if (int'(it.row) == cnt - 1) begin
                  pending_results.push_back(make_result(KIND_COL_SUM, it, col_sum[c],
                                                        col_flag[c] ? ST_SAT : ST_OK));
               end
            end
            CMD_BACKWARD: begin
               flag = grad_flag[addr];
               grad_store[addr] = clamp_add(grad_store[addr],
                                            widen(it.value) * widen(it.col_grad), flag);
               grad_flag[addr] = flag;
               if (it.want_input_grad) begin
                  pending_results.push_back(make_result(KIND_INPUT_GRAD, it,
                     widen(weight_mem[addr]) * widen(it.col_grad), ST_OK));
               end
            end
            default: begin
               pending_results.push_back(make_result(KIND_WEIGHT_GRAD, it, grad_store[addr],
                                                     grad_flag[addr] ? ST_SAT : ST_OK));
               grad_store[addr] = 0;
               grad_flag[addr] = 1'b0;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compares one result beat against the oldest expectation.
      function void check_result(logic [1:0] kind, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [SUM_W-1:0] value,
                                 logic [1:0] status);
         result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected: kind %0h row %0h col %0h %0h st %0h",
                     $time, kind, row, col, value, status);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         compare_field("kind", SUM_W'(want.kind), SUM_W'(kind));
         compare_field("out_row", SUM_W'(want.out_row), SUM_W'(row));
         compare_field("out_col", SUM_W'(want.out_col), SUM_W'(col));
         compare_field("result_value", want.result_value, value);
         compare_field("status", SUM_W'(want.status), SUM_W'(status));
         if (status == ST_SAT) sat_seen++;
         if (status == ST_RANGE) range_seen++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CMD_W-1:0] req_command = CMD_WRITE_WEIGHT;
   logic [ROW_W-1:0] req_row = '0;
   logic [COL_W-1:0] req_col = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic signed [VAL_W-1:0] req_col_grad = '0;
   logic req_want_input_grad = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [ROW_W-1:0] rsp_out_row;
   logic [COL_W-1:0] rsp_out_col;
   logic signed [SUM_W-1:0] rsp_result_value;
   logic [1:0] rsp_status;
   logic csr_we = 1'b0;
   logic csr_index = CSR_CHUNK_COUNT;
   logic [CSR_W-1:0] csr_wdata = '0;

   layer_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int beats_sent = 0;
   int setting_changes = 0;
   bit col_started [MAX_CHUNK_LEN];

   chunk_weighted_sum_layer DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_row             (req_row),
      .req_col             (req_col),
      .req_value           (req_value),
      .req_col_grad        (req_col_grad),
      .req_want_input_grad (req_want_input_grad),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_result_value    (rsp_result_value),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: a long hold-off when asked, random stalls otherwise.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         sb.check_result(rsp_kind, rsp_out_row, rsp_out_col, rsp_result_value, rsp_status);
      end
   end

   initial begin
      #5000000;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic [VAL_W-1:0] pick_q14();
      case ($urandom_range(19))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return Q_NEG_MAX;
         3: return Q_NEG_ONE;
         4: return Q_ONE;
         5: return Q_ZERO;
         default: return VAL_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic item_type beat_of(logic [CMD_W-1:0] cmd, int row, int col,
                                        logic [VAL_W-1:0] value, logic [VAL_W-1:0] sg,
                                        bit want);
      item_type b;
      b.command = cmd;
      b.row = row[ROW_W-1:0];
      b.col = col[COL_W-1:0];
      b.value = value;
      b.col_grad = sg;
      b.want_input_grad = want;
      return b;
   endfunction

   // Offers one beat after a random idle run and waits for its handshake.
   task automatic send_beat(item_type it);
      int gap;
      bit in_range;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_row <= it.row;
      req_col <= it.col;
      req_value <= it.value;
      req_col_grad <= it.col_grad;
      req_want_input_grad <= it.want_input_grad;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      in_range = int'(it.row) < sb.eff_count() && int'(it.col) < sb.eff_length();
      if (in_range && it.command == CMD_FORWARD && it.row == 0) col_started[it.col] = 1'b1;
      if (in_range || it.command != CMD_WRITE_WEIGHT) beats_sent++;
      sb.note_beat(it);
   endtask

   // Drops valid and waits until every expected result has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_W-1:0] count_raw, logic [CSR_W-1:0] len_raw);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_CHUNK_COUNT;
      csr_wdata <= count_raw;
      @(posedge clock);
      sb.write_register(CSR_CHUNK_COUNT, count_raw);
      @(negedge clock);
      csr_index <= CSR_CHUNK_LENGTH;
      csr_wdata <= len_raw;
      @(posedge clock);
      sb.write_register(CSR_CHUNK_LENGTH, len_raw);
      @(negedge clock);
      csr_we <= 1'b0;
      setting_changes++;
   endtask

   // One register setting: load weights for a set of columns, then mostly
   // ordered forward passes and backward bursts, with some reads, rewrites,
   // out-of-range beats and forward beats out of order.
   task automatic run_phase(logic [CSR_W-1:0] count_raw, logic [CSR_W-1:0] len_raw,
                            int send_pct, int recv_pct, int quota, bit pressure);
      int cnt;
      int len;
      int goal;
      int pick;
      int r;
      int c;
      int k;
      int n;
      int i;
      logic [CMD_W-1:0] cmd;
      logic [VAL_W-1:0] v;
      int cols[$];
      bit taken [MAX_CHUNK_LEN];
      bit loud;
      bit push;
      settle();
      configure(count_raw, len_raw);
      idle_pct = send_pct;
      stall_pct = recv_pct;
      cnt = sb.eff_count();
      len = sb.eff_length();
      goal = beats_sent + quota;
      for (c = 0; c < MAX_CHUNK_LEN; c++) taken[c] = 1'b0;
      if (len <= 6) begin
         for (c = 0; c < len; c++) cols.push_back(c);
      end else begin
         cols.push_back(0);
         cols.push_back(len - 1);
         taken[0] = 1'b1;
         taken[len - 1] = 1'b1;
         while (cols.size() < 5) begin
            c = $urandom_range(len - 2, 1);
            if (!taken[c]) begin
               taken[c] = 1'b1;
               cols.push_back(c);
            end
         end
      end

      // Every weight the phase will touch is written first.
      for (r = 0; r < cnt; r++) begin
         for (k = 0; k < cols.size(); k++) begin
            send_beat(beat_of(CMD_WRITE_WEIGHT, r, cols[k], pick_q14(), pick_q14(),
                              $urandom_range(1) != 0));
         end
      end
      if (pressure) hold_left = HOLD_OFF_CYCLES;

      while (beats_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // Full forward pass in row-major order; a loud pass drives the
            // column sums toward saturation.
            loud = ($urandom_range(4) == 0);
            for (r = 0; r < cnt; r++) begin
               for (k = 0; k < cols.size(); k++) begin
                  c = cols[k];
                  if (loud) begin
                     v = sb.weight_mem[r * MAX_CHUNK_LEN + c][VAL_W-1] ? Q_MIN : Q_MAX;
                  end else begin
                     v = pick_q14();
                  end
                  send_beat(beat_of(CMD_FORWARD, r, c, v, pick_q14(),
                                    $urandom_range(1) != 0));
               end
            end
         end else if (pick < 65) begin
            // Backward burst, often on one entry so gradients pile up.
            n = $urandom_range(8, 1);
            push = ($urandom_range(3) == 0);
            r = $urandom_range(cnt - 1);
            c = cols[$urandom_range(cols.size() - 1)];
            for (i = 0; i < n; i++) begin
               if ($urandom_range(1)) begin
                  r = $urandom_range(cnt - 1);
                  c = cols[$urandom_range(cols.size() - 1)];
               end
               send_beat(beat_of(CMD_BACKWARD, r, c, push ? Q_MIN : pick_q14(),
                                 push ? Q_MIN : pick_q14(), $urandom_range(3) != 0));
            end
         end else if (pick < 75) begin
            n = $urandom_range(4, 1);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(1)) begin
                  r = $urandom_range(cnt - 1);
                  c = cols[$urandom_range(cols.size() - 1)];
               end else begin
                  r = $urandom_range(cnt - 1);
                  c = $urandom_range(len - 1);
               end
               send_beat(beat_of(CMD_READ_GRAD, r, c, pick_q14(), pick_q14(),
                                 $urandom_range(1) != 0));
            end
         end else if (pick < 82) begin
            r = $urandom_range(cnt - 1);
            c = cols[$urandom_range(cols.size() - 1)];
            send_beat(beat_of(CMD_WRITE_WEIGHT, r, c, pick_q14(), pick_q14(),
                              $urandom_range(1) != 0));
         end else if (pick < 91 && (cnt < MAX_CHUNKS || len < MAX_CHUNK_LEN)) begin
            // Beat outside the configured shape.
            cmd = CMD_W'($urandom_range(3));
            if (cnt < MAX_CHUNKS && (len == MAX_CHUNK_LEN || $urandom_range(1))) begin
               r = $urandom_range(MAX_CHUNKS - 1, cnt);
               c = $urandom_range(MAX_CHUNK_LEN - 1);
            end else begin
               r = $urandom_range(MAX_CHUNKS - 1);
               c = $urandom_range(MAX_CHUNK_LEN - 1, len);
            end
            send_beat(beat_of(cmd, r, c, pick_q14(), pick_q14(), $urandom_range(1) != 0));
         end else begin
            // Forward beat out of sequence, on a column that has been opened.
            r = $urandom_range(cnt - 1);
            c = cols[$urandom_range(cols.size() - 1)];
            if (!col_started[c]) r = 0;
            send_beat(beat_of(CMD_FORWARD, r, c, pick_q14(), pick_q14(),
                              $urandom_range(1) != 0));
         end
      end
   endtask

   initial begin
      sb = new();
      for (int i = 0; i < MAX_CHUNK_LEN; i++) col_started[i] = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset shape, one row of one column: products at the extremes,
      // gradient saturation and readout, and out-of-range beats.
      send_beat(beat_of(CMD_WRITE_WEIGHT, 0, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 0, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_BACKWARD, 0, 0, Q_MIN, Q_MIN, 1'b1));
      send_beat(beat_of(CMD_BACKWARD, 0, 0, Q_MIN, Q_MIN, 1'b0));
      send_beat(beat_of(CMD_READ_GRAD, 0, 0, Q_ZERO, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_READ_GRAD, 0, 0, Q_MAX, Q_MAX, 1'b1));
      send_beat(beat_of(CMD_WRITE_WEIGHT, 7, 63, Q_MAX, Q_MAX, 1'b1));
      send_beat(beat_of(CMD_FORWARD, 7, 63, Q_MAX, Q_MIN, 1'b1));
      send_beat(beat_of(CMD_BACKWARD, 0, 63, Q_MIN, Q_MAX, 1'b0));
      send_beat(beat_of(CMD_READ_GRAD, 5, 0, Q_NEG_ONE, Q_NEG_ONE, 1'b1));
      send_beat(beat_of(CMD_WRITE_WEIGHT, 0, 0, Q_MAX, Q_NEG_ONE, 1'b1));
      send_beat(beat_of(CMD_FORWARD, 0, 0, Q_MAX, Q_ONE, 1'b0));
      send_beat(beat_of(CMD_BACKWARD, 0, 0, Q_MAX, Q_MIN, 1'b1));
      send_beat(beat_of(CMD_BACKWARD, 0, 0, Q_MIN, Q_MAX, 1'b1));
      send_beat(beat_of(CMD_READ_GRAD, 0, 0, Q_ZERO, Q_ZERO, 1'b0));

      // Two rows of two columns: one column saturates, the other nearly cancels,
      // and a new row 0 clears the saturation.
      settle();
      configure(7'd2, 7'd2);
      send_beat(beat_of(CMD_WRITE_WEIGHT, 0, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_WRITE_WEIGHT, 0, 1, Q_MAX, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_WRITE_WEIGHT, 1, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_WRITE_WEIGHT, 1, 1, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 0, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 0, 1, Q_MAX, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 1, 0, Q_MIN, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 1, 1, Q_MAX, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 0, 0, Q_ZERO, Q_ZERO, 1'b0));
      send_beat(beat_of(CMD_FORWARD, 1, 0, Q_ONE, Q_ZERO, 1'b0));

      // Random phases over several shapes, the clamped extremes among them.
      run_phase(7'd0, 7'd0, 0, 0, 110, 1'b0);
      run_phase(7'd3, 7'd5, 54, 0, 130, 1'b0);
      run_phase(7'd8, 7'd64, 0, 0, 140, 1'b1);
      run_phase(7'h7F, 7'h7F, 0, 54, 130, 1'b0);
      run_phase(7'd2, 7'd100, 10, 10, 130, 1'b0);
      run_phase(7'd5, 7'd1, 54, 0, 130, 1'b0);
      run_phase(7'd1, 7'd64, 0, 54, 130, 1'b0);
      run_phase(7'd4, 7'd7, 10, 10, 130, 1'b0);
      settle();

      $display("Covered %0d input beats over %0d register settings; %0d results checked.",
               beats_sent, setting_changes, sb.checked);
      $display("Saturated results seen: %0d, out-of-range results seen: %0d.",
               sb.sat_seen, sb.range_seen);
      if (sb.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
